### sv/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg
// Types, codes and constants shared by the torque homing sequencer.
// ----------------------------------------------------------------------------
package ths_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RAPID    = 3'd1,
        PH_BACKOFF  = 3'd2,
        PH_TOUCH    = 3'd3,
        PH_RETRACT  = 3'd4,
        PH_DONE     = 3'd5,
        PH_ERROR    = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TIMEOUT   = 3'd1,
        ERR_NO_RAPID  = 3'd2,
        ERR_NO_TOUCH  = 3'd3,
        ERR_INVALID   = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        REG_BACK_OFF  = 3'd0,
        REG_RETRACT   = 3'd1,
        REG_TIMEOUT   = 3'd2,
        REG_TOUCH_SPD = 3'd3,
        REG_RAPID_SPD = 3'd4,
        REG_ACCEL     = 3'd5,
        REG_TORQUE    = 3'd6
    } t_reg_idx;

    localparam logic [29:0] BACK_OFF_RST  = 30'd100;
    localparam logic [29:0] RETRACT_RST   = 30'd1000;
    localparam logic [31:0] TIMEOUT_RST   = 32'd2000000;
    localparam logic [23:0] TOUCH_SPD_RST = 24'd1000;
    localparam logic [23:0] RAPID_SPD_RST = 24'd5000;
    localparam logic [23:0] ACCEL_RST     = 24'd50000;
    localparam logic [6:0]  TORQUE_RST    = 7'd50;
    localparam logic [6:0]  TORQUE_MAX    = 7'd100;
    localparam logic [31:0] TOUCH_LEN_DEF = 32'd200;

    typedef struct packed {
        logic        func;
        logic        home_axis;
        logic [31:0] now_ms;
        logic        torque_hit;
        logic        moving;
        logic signed [31:0] position;
    } t_in_item;

    typedef struct packed {
        logic        move_valid;
        logic signed [31:0] move_steps;
        logic [23:0] move_speed;
        logic [23:0] move_accel;
        logic [6:0]  move_torque;
        logic        abort_move;
        logic        ref_valid;
        logic        ref_axis;
        logic signed [31:0] ref_position;
        logic [2:0]  phase;
        logic [2:0]  error_code;
        logic        returned_idle;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_beat;

    typedef struct packed {
        logic [29:0] backoff_len;
        logic [29:0] retract_steps;
        logic [31:0] timeout_ms;
        logic [23:0] touch_speed;
        logic [23:0] rapid_speed;
        logic [23:0] accel;
        logic [6:0]  torque_percent;
    } t_cfg_regs;

    typedef struct packed {
        t_phase      phase;
        logic        axis;
        logic [31:0] start_time;
        t_err        err;
    } t_seq_state;

endpackage

### sv/ths_if.sv
// ----------------------------------------------------------------------------
// ths_if
// Valid/ready channels of the torque homing sequencer.
// ----------------------------------------------------------------------------
interface ths_in_if import ths_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ths_out_if import ths_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ths_cfg_if import ths_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### sv/ths_step.sv
// ----------------------------------------------------------------------------
// ths_step
// Next-state and result logic for one beat of the homing sequencer.
// ----------------------------------------------------------------------------
module ths_step import ths_pkg::*; (
    input  t_in_item   i_item,
    input  t_seq_state i_state,
    input  t_cfg_regs  i_cfg,
    output t_seq_state o_state,
    output t_out_item  o_result
);

    logic        w_dir_pos;
    logic        w_timed_out;
    logic [31:0] w_elapsed;
    logic [6:0]  w_torque;
    logic [31:0] w_touch_len;

    function automatic logic signed [31:0] f_dist(input logic pos, input logic [31:0] d);
        return pos ? signed'(d) : signed'(32'd0 - d);
    endfunction

    assign w_dir_pos   = i_state.axis;
    assign w_elapsed   = i_item.now_ms - i_state.start_time;
    assign w_timed_out = w_elapsed > i_cfg.timeout_ms;
    assign w_torque    = (i_cfg.torque_percent > TORQUE_MAX) ? TORQUE_MAX
                                                             : i_cfg.torque_percent;
    assign w_touch_len = (i_cfg.backoff_len == 30'd0) ? TOUCH_LEN_DEF
                                                       : {1'b0, i_cfg.backoff_len, 1'b0};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_item.func) begin
            o_state.axis       = i_item.home_axis;
            o_state.start_time = i_item.now_ms;
            o_state.err        = ERR_NONE;
            o_state.phase      = PH_RAPID;
        end else begin
            unique case (i_state.phase)
                PH_IDLE: begin
                end
                PH_DONE, PH_ERROR: begin
                    o_state.phase          = PH_IDLE;
                    o_result.returned_idle = 1'b1;
                end
                PH_RAPID, PH_BACKOFF, PH_TOUCH, PH_RETRACT: begin
                    priority if (w_timed_out) begin
                        o_result.abort_move = 1'b1;
                        o_state.err         = ERR_TIMEOUT;
                        o_state.phase       = PH_ERROR;
                    end else if (i_item.torque_hit && i_state.phase == PH_RAPID) begin
                        o_state.phase        = PH_BACKOFF;
                        o_result.move_valid  = 1'b1;
                        o_result.move_steps  = f_dist(!w_dir_pos,
                                                      {2'b00, i_cfg.backoff_len});
                        o_result.move_speed  = i_cfg.touch_speed;
                        o_result.move_accel  = i_cfg.accel;
                        o_result.move_torque = w_torque;
                    end else if (i_item.torque_hit && i_state.phase == PH_TOUCH) begin
                        o_result.ref_valid    = 1'b1;
                        o_result.ref_axis     = i_state.axis;
                        o_result.ref_position = i_item.position;
                        o_state.phase         = PH_RETRACT;
                        o_result.move_valid   = 1'b1;
                        o_result.move_steps   = f_dist(!w_dir_pos,
                                                       {2'b00, i_cfg.retract_steps});
                        o_result.move_speed   = i_cfg.rapid_speed;
                        o_result.move_accel   = i_cfg.accel;
                        o_result.move_torque  = w_torque;
                    end else if (!i_item.moving) begin
                        unique case (i_state.phase)
                            PH_RAPID: begin
                                o_state.err   = ERR_NO_RAPID;
                                o_state.phase = PH_ERROR;
                            end
                            PH_BACKOFF: begin
                                o_state.phase        = PH_TOUCH;
                                o_result.move_valid  = 1'b1;
                                o_result.move_steps  = f_dist(w_dir_pos, w_touch_len);
                                o_result.move_speed  = i_cfg.touch_speed;
                                o_result.move_accel  = i_cfg.accel;
                                o_result.move_torque = w_torque;
                            end
                            PH_TOUCH: begin
                                o_state.err   = ERR_NO_TOUCH;
                                o_state.phase = PH_ERROR;
                            end
                            default: begin
                                o_state.err   = ERR_NONE;
                                o_state.phase = PH_DONE;
                            end
                        endcase
                    end
                end
                default: begin
                    o_state.err   = ERR_INVALID;
                    o_state.phase = PH_ERROR;
                end
            endcase
        end
        o_result.phase      = o_state.phase;
        o_result.error_code = o_state.err;
    end

endmodule

### sv/torque_homing_sequencer.sv
// ----------------------------------------------------------------------------
// torque_homing_sequencer
// Torque-sensing homing sequencer for one machine or cartridge axis.
// ----------------------------------------------------------------------------
// Each accepted input beat's result beat is registered and offered in the next cycle.
// Throughput: one beat per cycle while the output is ready; the result register frees as it is taken.
// The step logic is a 32-bit time subtract and compare, step negation and muxing.
// Reset: synchronous, active low; idle phase, no error, registers at defaults.
// Configuration writes are always ready and take effect on the next beat.
// ----------------------------------------------------------------------------
module torque_homing_sequencer import ths_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ths_cfg_if.sink   i_cfg,
    ths_in_if.sink    i_in,
    ths_out_if.source o_out
);

    t_cfg_regs  r_cfg;
    t_seq_state r_state;
    t_seq_state n_state;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       r_out_valid;
    logic       w_in_fire;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    ths_step u_step (
        .i_item   (i_in.data),
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.backoff_len    <= BACK_OFF_RST;
            r_cfg.retract_steps  <= RETRACT_RST;
            r_cfg.timeout_ms     <= TIMEOUT_RST;
            r_cfg.touch_speed    <= TOUCH_SPD_RST;
            r_cfg.rapid_speed    <= RAPID_SPD_RST;
            r_cfg.accel          <= ACCEL_RST;
            r_cfg.torque_percent <= TORQUE_RST;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.data.index))
                REG_BACK_OFF:  r_cfg.backoff_len    <= i_cfg.data.data[29:0];
                REG_RETRACT:   r_cfg.retract_steps  <= i_cfg.data.data[29:0];
                REG_TIMEOUT:   r_cfg.timeout_ms     <= i_cfg.data.data;
                REG_TOUCH_SPD: r_cfg.touch_speed    <= i_cfg.data.data[23:0];
                REG_RAPID_SPD: r_cfg.rapid_speed    <= i_cfg.data.data[23:0];
                REG_ACCEL:     r_cfg.accel          <= i_cfg.data.data[23:0];
                REG_TORQUE:    r_cfg.torque_percent <= i_cfg.data.data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.axis       <= 1'b0;
            r_state.start_time <= 32'd0;
            r_state.err        <= ERR_NONE;
            r_out_valid        <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out <= n_out;
        end
    end

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_out_valid)
        else $error("accepted beat produced no result");

    a_result_tracks_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.phase == r_state.phase && r_out.error_code == r_state.err))
        else $error("held result disagrees with sequencer state");

    a_ref_with_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ref_valid) |-> r_out.move_valid)
        else $error("reference captured without retract move");

    a_abort_is_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.abort_move) |->
            (r_out.phase == PH_ERROR && r_out.error_code == ERR_TIMEOUT))
        else $error("abort without timeout error");

    a_idle_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.returned_idle) |-> r_out.phase == PH_IDLE)
        else $error("return to idle left a non-idle phase");

endmodule

### tb/sv/torque_homing_sequencer_test.sv
// ----------------------------------------------------------------------------
// torque_homing_sequencer_test
// Drives homing commands and polls into the sequencer and checks each result
// beat against an in-bench model of the phase machine, with random gaps and
// stalls on both channels, several register settings and a long output hold.
// ----------------------------------------------------------------------------
module torque_homing_sequencer_test;
    import ths_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int   HALF_PERIOD  = 5;
    localparam int   RESET_CYCLES = 5;
    localparam int   DRAIN_CYCLES = 3;
    localparam int   WATCHDOG_NS  = 2_000_000;
    localparam int   MAX_REPORTS  = 10;
    localparam logic FUNC_POLL      = 1'b0;
    localparam logic FUNC_START     = 1'b1;
    localparam logic AXIS_MACHINE   = 1'b0;
    localparam logic AXIS_CARTRIDGE = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ths_cfg_if cfg_ch ();
    ths_in_if  in_ch ();
    ths_out_if out_ch ();

    torque_homing_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_cfg_regs   model_cfg;
    t_seq_state  model_seq;
    t_out_item   pending_results[$];
    logic [31:0] clock_ms;
    bit          idle_on;
    int          hold_request;
    int          fail_count;
    int          n_items;
    int          n_results;
    int          n_settings;
    int          n_refs;
    int          n_aborts;
    int          n_returns;

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_out_item with_move(input t_out_item r, input logic positive,
                                            input logic [31:0] span, input logic [23:0] speed);
        t_out_item m;
        m = r;
        m.move_valid  = 1'b1;
        m.move_steps  = positive ? span : -span;
        m.move_speed  = speed;
        m.move_accel  = model_cfg.accel;
        m.move_torque = (model_cfg.torque_percent > TORQUE_MAX) ? TORQUE_MAX
                                                                : model_cfg.torque_percent;
        return m;
    endfunction

    function automatic t_out_item advance_homing(input t_in_item it);
        t_out_item   r;
        logic        toward_pos;
        logic [31:0] elapsed;
        logic [31:0] touch_len;
        r          = '0;
        toward_pos = model_seq.axis;
        elapsed    = it.now_ms - model_seq.start_time;
        touch_len  = (model_cfg.backoff_len == '0) ? TOUCH_LEN_DEF
                                                   : {1'b0, model_cfg.backoff_len, 1'b0};
        if (it.func == FUNC_START) begin
            model_seq.axis       = it.home_axis;
            model_seq.start_time = it.now_ms;
            model_seq.err        = ERR_NONE;
            model_seq.phase      = PH_RAPID;
        end else if (model_seq.phase == PH_DONE || model_seq.phase == PH_ERROR) begin
            model_seq.phase = PH_IDLE;
            r.returned_idle = 1'b1;
        end else if (model_seq.phase >= PH_RAPID && model_seq.phase <= PH_RETRACT) begin
            if (elapsed > model_cfg.timeout_ms) begin
                r.abort_move    = 1'b1;
                model_seq.err   = ERR_TIMEOUT;
                model_seq.phase = PH_ERROR;
            end else if (it.torque_hit && model_seq.phase == PH_RAPID) begin
                model_seq.phase = PH_BACKOFF;
                r = with_move(r, !toward_pos, {2'b00, model_cfg.backoff_len},
                              model_cfg.touch_speed);
            end else if (it.torque_hit && model_seq.phase == PH_TOUCH) begin
                r.ref_valid     = 1'b1;
                r.ref_axis      = model_seq.axis;
                r.ref_position  = it.position;
                model_seq.phase = PH_RETRACT;
                r = with_move(r, !toward_pos, {2'b00, model_cfg.retract_steps},
                              model_cfg.rapid_speed);
            end else if (!it.moving) begin
                case (model_seq.phase)
                    PH_RAPID: begin
                        model_seq.err   = ERR_NO_RAPID;
                        model_seq.phase = PH_ERROR;
                    end
                    PH_BACKOFF: begin
                        model_seq.phase = PH_TOUCH;
                        r = with_move(r, toward_pos, touch_len, model_cfg.touch_speed);
                    end
                    PH_TOUCH: begin
                        model_seq.err   = ERR_NO_TOUCH;
                        model_seq.phase = PH_ERROR;
                    end
                    default: begin
                        model_seq.err   = ERR_NONE;
                        model_seq.phase = PH_DONE;
                    end
                endcase
            end
        end else if (model_seq.phase != PH_IDLE) begin
            model_seq.err   = ERR_INVALID;
            model_seq.phase = PH_ERROR;
        end
        r.phase      = model_seq.phase;
        r.error_code = model_seq.err;
        return r;
    endfunction

    function automatic t_in_item poll_item(input logic [31:0] now, input logic torque,
                                           input logic moving, input logic [31:0] pos);
        t_in_item it;
        it.func       = FUNC_POLL;
        it.home_axis  = 1'($urandom_range(0, 1));
        it.now_ms     = now;
        it.torque_hit = torque;
        it.moving     = moving;
        it.position   = pos;
        return it;
    endfunction

    function automatic t_in_item start_item(input logic axis, input logic [31:0] now);
        t_in_item it;
        it = poll_item(now, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
        it.func      = FUNC_START;
        it.home_axis = axis;
        return it;
    endfunction

    function automatic logic [31:0] random_setting(input t_reg_idx ri);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            2: v = $urandom;
            default: begin
                case (ri)
                    REG_BACK_OFF, REG_RETRACT: v = $urandom_range(1, 5000);
                    REG_TIMEOUT:               v = $urandom_range(100, 200000);
                    REG_TORQUE:                v = $urandom_range(0, 127);
                    default:                   v = $urandom_range(0, 24'hFF_FFFF);
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic string field_diffs(input t_out_item want, input t_out_item got);
        string s;
        s = "";
        if (got.move_valid !== want.move_valid)
            s = {s, $sformatf(" move_valid %0h/%0h", want.move_valid, got.move_valid)};
        if (got.move_steps !== want.move_steps)
            s = {s, $sformatf(" move_steps %0h/%0h", want.move_steps, got.move_steps)};
        if (got.move_speed !== want.move_speed)
            s = {s, $sformatf(" move_speed %0h/%0h", want.move_speed, got.move_speed)};
        if (got.move_accel !== want.move_accel)
            s = {s, $sformatf(" move_accel %0h/%0h", want.move_accel, got.move_accel)};
        if (got.move_torque !== want.move_torque)
            s = {s, $sformatf(" move_torque %0d/%0d", want.move_torque, got.move_torque)};
        if (got.abort_move !== want.abort_move)
            s = {s, $sformatf(" abort_move %0h/%0h", want.abort_move, got.abort_move)};
        if (got.ref_valid !== want.ref_valid)
            s = {s, $sformatf(" ref_valid %0h/%0h", want.ref_valid, got.ref_valid)};
        if (got.ref_axis !== want.ref_axis)
            s = {s, $sformatf(" ref_axis %0h/%0h", want.ref_axis, got.ref_axis)};
        if (got.ref_position !== want.ref_position)
            s = {s, $sformatf(" ref_position %0h/%0h", want.ref_position, got.ref_position)};
        if (got.phase !== want.phase)
            s = {s, $sformatf(" phase %0d/%0d", want.phase, got.phase)};
        if (got.error_code !== want.error_code)
            s = {s, $sformatf(" error_code %0d/%0d", want.error_code, got.error_code)};
        if (got.returned_idle !== want.returned_idle)
            s = {s, $sformatf(" returned_idle %0h/%0h", want.returned_idle, got.returned_idle)};
        return s;
    endfunction

    function automatic void report_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("ERROR (expected/actual): %s", msg);
    endfunction

    // one command beat; valid stays high after acceptance so beats can run back to back
    task automatic push_cmd(input t_in_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        pending_results.push_back(advance_homing(it));
        n_items++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        t_cfg_beat beat;
        beat.index = idx;
        beat.data  = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= beat;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            REG_BACK_OFF:  model_cfg.backoff_len    = value[29:0];
            REG_RETRACT:   model_cfg.retract_steps  = value[29:0];
            REG_TIMEOUT:   model_cfg.timeout_ms     = value;
            REG_TOUCH_SPD: model_cfg.touch_speed    = value[23:0];
            REG_RAPID_SPD: model_cfg.rapid_speed    = value[23:0];
            REG_ACCEL:     model_cfg.accel          = value[23:0];
            REG_TORQUE:    model_cfg.torque_percent = value[6:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed homing runs steered by the model phase, with some noise
    task automatic random_homing(input int n_beats);
        t_in_item it;
        for (int k = 0; k < n_beats; k++) begin
            if ($urandom_range(0, 3) != 0) clock_ms += $urandom_range(1, 60);
            if ($urandom_range(0, 49) == 0) clock_ms += model_cfg.timeout_ms;
            it = poll_item(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           $urandom);
            case (model_seq.phase)
                PH_IDLE: begin
                    if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
                    it = start_item(1'($urandom_range(0, 1)), clock_ms);
                end
                PH_RAPID: begin
                    it.torque_hit = ($urandom_range(0, 3) == 0);
                    it.moving     = ($urandom_range(0, 19) != 0);
                end
                PH_BACKOFF, PH_RETRACT: begin
                    it.moving = ($urandom_range(0, 2) != 0);
                end
                PH_TOUCH: begin
                    it.torque_hit = ($urandom_range(0, 2) == 0);
                    it.moving     = ($urandom_range(0, 14) != 0);
                end
                default: ;
            endcase
            if ($urandom_range(0, 39) == 0) it.func = FUNC_START;
            if ($urandom_range(0, 11) == 0) begin
                it = poll_item(clock_ms, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               $urandom);
                it.func = ($urandom_range(0, 3) == 0) ? FUNC_START : FUNC_POLL;
            end
            push_cmd(it);
        end
    endtask

    task automatic test_machine_homing();
        logic [31:0] t;
        t = 32'd1000;
        push_cmd(poll_item(t, 1'b1, 1'b0, $urandom));          // poll while idle
        push_cmd(start_item(AXIS_MACHINE, t));
        push_cmd(poll_item(t + 5, 1'b0, 1'b1, $urandom));
        push_cmd(poll_item(t + 10, 1'b1, 1'b1, $urandom));     // torque wins over moving
        push_cmd(poll_item(t + 15, 1'b1, 1'b0, $urandom));     // torque ignored in back-off
        push_cmd(poll_item(t + 20, 1'b0, 1'b1, $urandom));
        push_cmd(poll_item(t + 25, 1'b1, 1'b0, 32'h8000_0000));
        push_cmd(poll_item(t + 30, 1'b0, 1'b0, $urandom));
        push_cmd(poll_item(t + 35, 1'b0, 1'b0, $urandom));
    endtask

    task automatic test_error_paths();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        push_cmd(start_item(AXIS_MACHINE, t0));
        push_cmd(poll_item(t0 + 1, 1'b1, 1'b1, $urandom));
        push_cmd(start_item(AXIS_CARTRIDGE, t0 + 2));           // restart mid back-off
        push_cmd(poll_item(t0 + 3, 1'b0, 1'b0, $urandom));      // stopped without torque
        push_cmd(poll_item(t0 + 4, 1'b0, 1'b0, $urandom));      // idle, error kept
        push_cmd(start_item(AXIS_MACHINE, t0 + 5));
        push_cmd(poll_item(t0 + 6, 1'b1, 1'b0, $urandom));
        push_cmd(poll_item(t0 + 7, 1'b0, 1'b0, $urandom));
        push_cmd(poll_item(t0 + 8, 1'b0, 1'b0, $urandom));      // no torque at touch-off
        push_cmd(start_item(AXIS_CARTRIDGE, t0));                // restart from error
        push_cmd(poll_item(t0 + TIMEOUT_RST, 1'b0, 1'b1, $urandom));
        push_cmd(poll_item(t0 + TIMEOUT_RST + 1, 1'b1, 1'b1, $urandom));
        push_cmd(poll_item(t0, 1'b0, 1'b0, $urandom));
    endtask

    task automatic test_cartridge_extremes();
        settle();
        write_reg(REG_BACK_OFF, 32'h0);
        write_reg(REG_RETRACT, 32'hFFFF_FFFF);
        write_reg(REG_TOUCH_SPD, 32'h0);
        write_reg(REG_RAPID_SPD, 32'hFFFF_FFFF);
        write_reg(REG_ACCEL, 32'hFFFF_FFFF);
        write_reg(REG_TORQUE, 32'h7F);                           // saturates to 100
        cfg_ch.valid <= 1'b0;
        n_settings++;
        push_cmd(start_item(AXIS_CARTRIDGE, 32'h7FFF_FFF0));
        push_cmd(poll_item(32'h7FFF_FFF1, 1'b1, 1'b1, $urandom));
        push_cmd(poll_item(32'h7FFF_FFF2, 1'b0, 1'b0, $urandom)); // default touch length
        push_cmd(poll_item(32'h7FFF_FFF3, 1'b1, 1'b1, 32'h7FFF_FFFF));
        push_cmd(poll_item(32'h7FFF_FFF4, 1'b0, 1'b0, $urandom));
    endtask

    task automatic test_random_settings();
        t_reg_idx    ri;
        logic [31:0] v;
        for (int s = 0; s < 6; s++) begin
            settle();
            ri = ri.first();
            do begin
                v = (s == 0) ? 32'hFFFF_FFFF : ((s == 1) ? 32'h0 : random_setting(ri));
                write_reg(ri, v);
                ri = ri.next();
            end while (ri != ri.first());
            cfg_ch.valid <= 1'b0;
            n_settings++;
            random_homing(120);
        end
    endtask

    task automatic test_output_backpressure();
        settle();
        idle_on      = 1'b0;
        hold_request = 80;
        random_homing(40);
        idle_on      = 1'b1;
    endtask

    task automatic test_steady_tail();
        idle_on = 1'b0;
        random_homing(150);
    endtask

    // result side: random stall bursts plus an occasional long hold
    initial begin : result_sink
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        string     diffs;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_failure($sformatf("result beat %0d with nothing expected", n_results));
            end else begin
                want  = pending_results.pop_front();
                diffs = field_diffs(want, out_ch.data);
                if (diffs != "") report_failure($sformatf("result beat %0d:%s", n_results, diffs));
                n_refs    += int'(want.ref_valid);
                n_aborts  += int'(want.abort_move);
                n_returns += int'(want.returned_idle);
            end
        end
    end

    initial begin
        #WATCHDOG_NS;
        $display("torque_homing_sequencer_test failed");
        $finish;
    end

    initial begin
        model_cfg = '{BACK_OFF_RST, RETRACT_RST, TIMEOUT_RST, TOUCH_SPD_RST,
                      RAPID_SPD_RST, ACCEL_RST, TORQUE_RST};
        model_seq    = '{PH_IDLE, AXIS_MACHINE, 32'd0, ERR_NONE};
        clock_ms     = 32'd5000;
        idle_on      = 1'b1;
        hold_request = 0;
        fail_count   = 0;
        n_items      = 0;
        n_results    = 0;
        n_settings   = 1;
        n_refs       = 0;
        n_aborts     = 0;
        n_returns    = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_machine_homing();
        test_error_paths();
        test_cartridge_extremes();
        test_random_settings();
        test_output_backpressure();
        test_steady_tail();
        settle();

        $display("summary: %0d command beats under %0d register settings, %0d result beats",
                 n_items, n_settings, n_results);
        $display("summary: %0d home references, %0d timeout aborts, %0d returns to idle",
                 n_refs, n_aborts, n_returns);
        if (fail_count == 0) begin
            $display("torque_homing_sequencer_test passed");
        end else begin
            $display("torque_homing_sequencer_test failed");
        end
        $finish;
    end

endmodule
